### hdl/eia_pkg.sv
// Shared types and constants for the entity ID allocator.
// No dependencies; compile first.
package eia_pkg;

  localparam int MODE_W          = 2;
  localparam int ID_FIELD_W      = 8;
  localparam int GEN_W           = 8;
  localparam int COUNT_FIELD_W   = 9;
  localparam int DEFAULT_MAX_IDS = 256;

  typedef enum logic [MODE_W-1:0] {
    MODE_CREATE  = 2'd0,
    MODE_DESTROY = 2'd1,
    MODE_QUERY   = 2'd2,
    MODE_CLEAR   = 2'd3
  } mode_t;

  typedef struct packed {
    logic                     ok;
    logic [ID_FIELD_W-1:0]    granted_id;
    logic [GEN_W-1:0]         granted_generation;
    logic                     is_alive;
    logic [COUNT_FIELD_W-1:0] live_count;
  } result_t;

endpackage

### hdl/eia_if.sv
// Request and response channel interfaces (valid/ready) for the allocator.
// Depends on eia_pkg.
interface eia_req_if;
  import eia_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [MODE_W-1:0]     mode;
  logic [ID_FIELD_W-1:0] entity_id;

  modport source (output valid, output mode, output entity_id, input ready);
  modport sink   (input valid, input mode, input entity_id, output ready);
endinterface

interface eia_rsp_if;
  import eia_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     ok;
  logic [ID_FIELD_W-1:0]    granted_id;
  logic [GEN_W-1:0]         granted_generation;
  logic                     is_alive;
  logic [COUNT_FIELD_W-1:0] live_count;

  modport source (output valid, output ok, output granted_id, output granted_generation,
                  output is_alive, output live_count, input ready);
  modport sink   (input valid, input ok, input granted_id, input granted_generation,
                  input is_alive, input live_count, output ready);
endinterface

### hdl/entity_id_allocator_unit.sv
// Entity ID allocator: generational handles with a FIFO free list.
// A response word passes through the execute register, then the response
// register, before it is offered to the sink.
// Throughput: one request per cycle; stalls only on response back-pressure.
// Reset (rst, synchronous) clears pointers, counts and pipeline valids; the
// entry table and free queue RAMs are not cleared, high_water masks them.
module entity_id_allocator_unit #(
  parameter int MAX_IDS = eia_pkg::DEFAULT_MAX_IDS
) (
  input  logic clk,
  input  logic rst,
  eia_req_if.sink   req,
  eia_rsp_if.source rsp
);
  import eia_pkg::*;

  localparam int IW = $clog2(MAX_IDS);        // ID / pointer width
  localparam int CW = $clog2(MAX_IDS + 1);    // count width, holds MAX_IDS
  localparam int XW = (CW > ID_FIELD_W) ? CW : ID_FIELD_W;
  localparam int EW = 1 + GEN_W;              // entry: {alive, generation}
  localparam int QW = IW + GEN_W;             // queue word: {id, generation}

  // Allocator state
  logic [IW-1:0] head, head_next;
  logic [IW-1:0] tail, tail_next;
  logic [CW-1:0] fill, fill_next;
  logic [CW-1:0] high_water, high_water_next;
  logic [CW-1:0] alive_total, alive_total_next;

  // Execute stage: request word plus the RAM words read at accept
  logic          b_valid;
  mode_t         b_mode;
  logic [ID_FIELD_W-1:0] b_id;
  logic [EW-1:0] ent_rdata;
  logic [QW-1:0] q_rdata;

  // RAM write ports, driven from the execute stage
  logic          ent_we;
  logic [IW-1:0] ent_waddr;
  logic [EW-1:0] ent_wdata;
  logic          q_we;
  logic [IW-1:0] q_waddr;
  logic [QW-1:0] q_wdata;

  logic    b_fire;
  logic    accept;
  logic    in_range;
  logic    alive_hit;
  result_t result;

  function automatic logic [IW-1:0] ptr_inc(input logic [IW-1:0] p);
    ptr_inc = (p == IW'(MAX_IDS - 1)) ? '0 : p + 1'b1;
  endfunction

  // Execute retires when the response register is free or draining.
  assign b_fire    = b_valid && (!rsp.valid || rsp.ready);
  assign req.ready = !b_valid || b_fire;
  assign accept    = req.valid && req.ready;

  // high_water never exceeds MAX_IDS, so this also bounds the ID range.
  assign in_range  = XW'(b_id) < XW'(high_water);
  assign alive_hit = in_range && ent_rdata[EW-1];

  // Entry table, indexed by ID. Only entries below high_water are ever read
  // as meaningful; every such entry was written by a fresh create.
  eia_ram #(.DEPTH(MAX_IDS), .WIDTH(EW)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .re    (accept),
    .raddr (IW'(req.entity_id)),
    .rdata (ent_rdata)
  );

  // Free queue ring. The head word is fetched at accept using the head
  // pointer as it will stand once the item ahead has retired.
  eia_ram #(.DEPTH(MAX_IDS), .WIDTH(QW)) u_free_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .re    (accept),
    .raddr (head_next),
    .rdata (q_rdata)
  );

  always_comb begin
    head_next        = head;
    tail_next        = tail;
    fill_next        = fill;
    high_water_next  = high_water;
    alive_total_next = alive_total;
    ent_we           = 1'b0;
    ent_waddr        = IW'(b_id);
    ent_wdata        = '0;
    q_we             = 1'b0;
    q_waddr          = tail;
    q_wdata          = {IW'(b_id), ent_rdata[GEN_W-1:0]};
    result           = '0;

    if (b_fire) begin
      unique case (b_mode)
        MODE_CREATE: begin
          if (fill != '0) begin
            // recycle the oldest freed ID, bump its generation
            head_next        = ptr_inc(head);
            fill_next        = fill - 1'b1;
            alive_total_next = alive_total + 1'b1;
            ent_we           = 1'b1;
            ent_waddr        = q_rdata[QW-1:GEN_W];
            ent_wdata        = {1'b1, q_rdata[GEN_W-1:0] + 1'b1};
            result.ok                 = 1'b1;
            result.granted_id         = ID_FIELD_W'(q_rdata[QW-1:GEN_W]);
            result.granted_generation = q_rdata[GEN_W-1:0] + 1'b1;
          end else if (high_water != CW'(MAX_IDS)) begin
            // fresh ID, generation starts at zero
            high_water_next  = high_water + 1'b1;
            alive_total_next = alive_total + 1'b1;
            ent_we           = 1'b1;
            ent_waddr        = IW'(high_water);
            ent_wdata        = {1'b1, GEN_W'(0)};
            result.ok                 = 1'b1;
            result.granted_id         = ID_FIELD_W'(high_water);
            result.granted_generation = '0;
          end
        end
        MODE_DESTROY: begin
          if (alive_hit) begin
            ent_we    = 1'b1;
            ent_wdata = {1'b0, ent_rdata[GEN_W-1:0]};
            q_we      = 1'b1;
            tail_next = ptr_inc(tail);
            if (fill < CW'(MAX_IDS)) begin
              fill_next = fill + 1'b1;
            end
            if (alive_total != '0) begin
              alive_total_next = alive_total - 1'b1;
            end
            result.ok = 1'b1;
          end
        end
        MODE_QUERY: begin
          result.ok       = 1'b1;
          result.is_alive = alive_hit;
        end
        MODE_CLEAR: begin
          head_next        = '0;
          tail_next        = '0;
          fill_next        = '0;
          high_water_next  = '0;
          alive_total_next = '0;
          result.ok        = 1'b1;
        end
        default: begin
        end
      endcase
      result.live_count = COUNT_FIELD_W'(alive_total_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head        <= '0;
      tail        <= '0;
      fill        <= '0;
      high_water  <= '0;
      alive_total <= '0;
    end else begin
      head        <= head_next;
      tail        <= tail_next;
      fill        <= fill_next;
      high_water  <= high_water_next;
      alive_total <= alive_total_next;
    end
  end

  // Execute stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (accept) begin
      b_valid <= 1'b1;
    end else if (b_fire) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_mode <= mode_t'(req.mode);
      b_id   <= req.entity_id;
    end
  end

  // Response register: holds a word until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (b_fire) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire) begin
      rsp.ok                 <= result.ok;
      rsp.granted_id         <= result.granted_id;
      rsp.granted_generation <= result.granted_generation;
      rsp.is_alive           <= result.is_alive;
      rsp.live_count         <= result.live_count;
    end
  end

`ifndef SYNTHESIS
  // Every ID handed out since clear is either alive or waiting in the queue.
  a_conservation: assert property (@(posedge clk) disable iff (rst)
    ((CW + 1)'(fill) + (CW + 1)'(alive_total)) == (CW + 1)'(high_water))
    else $error("free fill plus live count differs from high water");

  // Ring occupancy must agree with the pointer distance.
  a_ring_span: assert property (@(posedge clk) disable iff (rst)
    (fill != '0 && fill != CW'(MAX_IDS)) |-> (head != tail))
    else $error("free queue pointers meet while partly full");

  // A retiring create that succeeds always leaves the live count higher.
  a_create_count: assert property (@(posedge clk) disable iff (rst)
    (b_fire && b_mode == MODE_CREATE && result.ok) |=>
      (alive_total == $past(alive_total) + 1'b1))
    else $error("successful create did not raise the live count");
`endif

endmodule

### hdl/eia_ram.sv
// Simple dual-port RAM, one write and one registered read port, with
// write-to-read forwarding on an address match. No dependencies.
module eia_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 9
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // same-cycle write wins so the next reader sees the newest word
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= (we && (waddr == raddr)) ? wdata : mem[raddr];
    end
  end

endmodule

### tb/sv/tb.sv
// Testbench for entity_id_allocator_unit: drives requests, predicts each response
// and checks it field by field. Depends on eia_pkg, eia_req_if/eia_rsp_if and the RTL.
module tb;
  import eia_pkg::*;

  localparam int NUM_IDS = DEFAULT_MAX_IDS;

  logic clk = 1'b0;
  logic rst;

  eia_req_if req_ch ();
  eia_rsp_if rsp_ch ();

  entity_id_allocator_unit #(.MAX_IDS(NUM_IDS)) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always #10 clk = ~clk;

  // Idle percentages, set per phase; stall_left is the long receiver hold-off.
  int send_idle_pct;
  int rcv_idle_pct;
  int stall_left;
  int error_count;

  // Allocator shadow state
  bit         alive_map [NUM_IDS];
  logic [7:0] gen_of    [NUM_IDS];
  logic [7:0] free_ring [NUM_IDS];
  int         ring_head, ring_tail, ring_fill;
  int         handed_out;   // IDs ever granted since the last clear
  int         live_total;

  // Responses still owed by the block, oldest first
  result_t pending_results[$];

  // Applies one accepted request word to the shadow state and returns the
  // response the block must give for it.
  function automatic result_t predict_allocation(input mode_t m, input logic [7:0] id);
    result_t r;
    int      g;
    r = '0;
    case (m)
      MODE_CREATE: begin
        if (ring_fill > 0) begin
          // reuse the oldest freed ID, next generation
          g = int'(free_ring[ring_head]);
          ring_head = (ring_head + 1) % NUM_IDS;
          ring_fill--;
          alive_map[g] = 1'b1;
          gen_of[g] = gen_of[g] + 8'd1;
          r.ok = 1'b1;
          r.granted_id = g[7:0];
          r.granted_generation = gen_of[g];
          live_total++;
        end else if (handed_out < NUM_IDS) begin
          // fresh ID starts at generation 0
          g = handed_out;
          handed_out++;
          alive_map[g] = 1'b1;
          gen_of[g] = 8'd0;
          r.ok = 1'b1;
          r.granted_id = g[7:0];
          live_total++;
        end
        // allocator full: fail, nothing changes
      end
      MODE_DESTROY: begin
        if (id < handed_out && alive_map[id]) begin
          alive_map[id] = 1'b0;
          free_ring[ring_tail] = id;
          ring_tail = (ring_tail + 1) % NUM_IDS;
          if (ring_fill < NUM_IDS) ring_fill++;
          if (live_total > 0) live_total--;
          r.ok = 1'b1;
        end
      end
      MODE_QUERY: begin
        r.ok = 1'b1;
        r.is_alive = (id < handed_out) && alive_map[id];
      end
      default: begin
        foreach (alive_map[i]) alive_map[i] = 1'b0;
        ring_head = 0;
        ring_tail = 0;
        ring_fill = 0;
        handed_out = 0;
        live_total = 0;
        r.ok = 1'b1;
      end
    endcase
    r.live_count = live_total[COUNT_FIELD_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [8:0] got,
                                 input logic [8:0] want);
    error_count++;
    $display("MISMATCH %s: got %0d, expected %0d at %0t", field, got, want, $time);
  endtask

  // Sends one request word; blocks until it is accepted, then records the
  // expected response. valid stays high from one word to the next unless the
  // sender decides to idle.
  task automatic send_word(input mode_t m, input logic [7:0] id);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.mode      <= m;
    req_ch.entity_id <= id;
    do @(posedge clk); while (!req_ch.ready);
    pending_results.insert(pending_results.size(), predict_allocation(m, id));
  endtask

  // Drops valid and waits until every owed response has come back.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_idle(input int send_pct, input int rcv_pct);
    send_idle_pct = send_pct;
    rcv_idle_pct  = rcv_pct;
  endtask

  // Mostly IDs that have been handed out (preferring alive ones), sometimes
  // any 8-bit value so out-of-range and never-used IDs are hit too.
  function automatic logic [7:0] pick_target_id();
    int cand;
    if (handed_out == 0 || $urandom_range(99) < 25) return 8'($urandom_range(255));
    cand = $urandom_range(handed_out - 1);
    for (int k = 0; k < 6 && !alive_map[cand]; k++) cand = $urandom_range(handed_out - 1);
    return cand[7:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Response side: drives ready (random idling plus the long hold-off) and
  // checks every accepted response word against the oldest prediction.
  // ---------------------------------------------------------------------------
  task automatic check_response();
    result_t seen;
    result_t want;
    seen.ok                 = rsp_ch.ok;
    seen.granted_id         = rsp_ch.granted_id;
    seen.granted_generation = rsp_ch.granted_generation;
    seen.is_alive           = rsp_ch.is_alive;
    seen.live_count         = rsp_ch.live_count;
    if (pending_results.size() == 0) begin
      report_mismatch("unexpected response, live_count", seen.live_count, 9'd0);
      return;
    end
    want = pending_results.pop_front();
    if (seen.ok !== want.ok) report_mismatch("ok", 9'(seen.ok), 9'(want.ok));
    if (seen.granted_id !== want.granted_id)
      report_mismatch("granted_id", 9'(seen.granted_id), 9'(want.granted_id));
    if (seen.granted_generation !== want.granted_generation)
      report_mismatch("granted_generation", 9'(seen.granted_generation),
                      9'(want.granted_generation));
    if (seen.is_alive !== want.is_alive)
      report_mismatch("is_alive", 9'(seen.is_alive), 9'(want.is_alive));
    if (seen.live_count !== want.live_count)
      report_mismatch("live_count", seen.live_count, want.live_count);
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) check_response();
    if (stall_left > 0) begin
      stall_left--;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked words: empty allocator, out-of-range and dead IDs, FIFO reuse
  // with generation bump, fresh IDs after the queue empties, clear.
  task automatic test_directed();
    send_word(MODE_QUERY,   8'h00);  // nothing handed out yet
    send_word(MODE_DESTROY, 8'hFF);  // out of range
    send_word(MODE_DESTROY, 8'h00);  // out of range
    send_word(MODE_CREATE,  8'hAA);  // id 0, gen 0
    send_word(MODE_CREATE,  8'h55);  // id 1
    send_word(MODE_CREATE,  8'hFF);  // id 2
    send_word(MODE_QUERY,   8'h01);
    send_word(MODE_QUERY,   8'hFF);  // out of range
    send_word(MODE_DESTROY, 8'h01);
    send_word(MODE_DESTROY, 8'h01);  // already dead
    send_word(MODE_QUERY,   8'h01);
    send_word(MODE_CREATE,  8'h00);  // reuse 1, gen 1
    send_word(MODE_DESTROY, 8'h00);
    send_word(MODE_DESTROY, 8'h02);
    send_word(MODE_CREATE,  8'h00);  // 0 comes out first
    send_word(MODE_CREATE,  8'h00);  // then 2
    send_word(MODE_CREATE,  8'h00);  // queue empty: fresh id 3
    send_word(MODE_CLEAR,   8'hFF);
    send_word(MODE_QUERY,   8'h00);  // out of range again
    send_word(MODE_DESTROY, 8'h03);
    send_word(MODE_CREATE,  8'h00);  // id 0 back at gen 0
    send_word(MODE_QUERY,   8'h00);
  endtask

  // Fill every ID, hit the full case, free all in a scrambled order and take
  // them all back so the queue wraps completely.
  task automatic test_full_allocator();
    send_word(MODE_CLEAR, 8'h00);
    for (int i = 0; i < NUM_IDS; i++) send_word(MODE_CREATE, 8'($urandom_range(255)));
    send_word(MODE_CREATE,  8'h00);  // full
    send_word(MODE_QUERY,   8'hFF);
    send_word(MODE_DESTROY, 8'hFF);
    send_word(MODE_DESTROY, 8'h00);
    send_word(MODE_CREATE,  8'h00);
    send_word(MODE_CREATE,  8'h00);
    send_word(MODE_CREATE,  8'h00);  // full again
    // 37 is odd, so this walks a permutation of all IDs
    for (int i = 0; i < NUM_IDS; i++) send_word(MODE_DESTROY, 8'((i * 37) % NUM_IDS));
    send_word(MODE_DESTROY, 8'h25);  // dead by now
    for (int i = 0; i < NUM_IDS; i++) send_word(MODE_CREATE, 8'($urandom_range(255)));
    send_word(MODE_CREATE, 8'h00);
  endtask

  // One ID recycled past 256 generations so the counter wraps.
  task automatic test_generation_wrap();
    send_word(MODE_CLEAR, 8'h00);
    repeat (4) send_word(MODE_CREATE, 8'h00);
    repeat (260) begin
      send_word(MODE_DESTROY, 8'h02);
      send_word(MODE_CREATE,  8'h02);
    end
    send_word(MODE_QUERY, 8'h02);
  endtask

  // Receiver holds off for a long stretch while words keep coming, so the
  // block backs up and drops req.ready; then the sender waits for a full drain.
  task automatic test_back_pressure();
    stall_left = 80;
    repeat (40) begin
      if ($urandom_range(1)) send_word(MODE_CREATE, 8'($urandom_range(255)));
      else send_word(MODE_QUERY, pick_target_id());
    end
    wait_drained();
    repeat (8) send_word(MODE_DESTROY, pick_target_id());
  endtask

  // Random traffic in chunks with different create weights so the live count
  // climbs, churns and drains; clears are rare.
  task automatic test_random_traffic(input int n_words);
    int    w_create;
    int    chunk_left;
    mode_t m;
    chunk_left = 0;
    w_create   = 50;
    repeat (n_words) begin
      if (chunk_left == 0) begin
        case ($urandom_range(2))
          0:       w_create = 15;
          1:       w_create = 45;
          default: w_create = 85;
        endcase
        chunk_left = $urandom_range(60, 20);
      end
      chunk_left--;
      if ($urandom_range(199) == 0) m = MODE_CLEAR;
      else if ($urandom_range(99) < w_create) m = MODE_CREATE;
      else if ($urandom_range(99) < 55) m = MODE_DESTROY;
      else m = MODE_QUERY;
      send_word(m, pick_target_id());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.mode      = MODE_CREATE;
    req_ch.entity_id = '0;
    rsp_ch.ready     = 1'b0;
    error_count = 0;
    stall_left  = 0;
    ring_head = 0;
    ring_tail = 0;
    ring_fill = 0;
    handed_out = 0;
    live_total = 0;
    foreach (alive_map[i]) begin
      alive_map[i] = 1'b0;
      gen_of[i]    = 8'd0;
      free_ring[i] = 8'd0;
    end
    set_idle(16, 52);
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_full_allocator();
    test_random_traffic(110);
    wait_drained();

    set_idle(52, 16);
    test_generation_wrap();
    test_random_traffic(110);
    wait_drained();

    set_idle(0, 0);
    test_back_pressure();
    test_random_traffic(110);

    wait_drained();
    repeat (10) @(posedge clk);
    if (error_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
